// ===== rtl/accumulator_machine_step_assert.svh =====
// assertion helpers for the accumulator machine
`ifndef ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`define ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define AMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ams_pkg.sv =====
package ams_pkg;

  localparam int unsigned WordW = 16;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_STOP  = 3'd1,
    ST_BADOP = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MULT   = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_JMP    = 4'd5;
  localparam logic [3:0] OP_JMPN   = 4'd6;
  localparam logic [3:0] OP_JMPP   = 4'd7;
  localparam logic [3:0] OP_JMPZ   = 4'd8;
  localparam logic [3:0] OP_COPY   = 4'd9;
  localparam logic [3:0] OP_LOAD   = 4'd10;
  localparam logic [3:0] OP_STORE  = 4'd11;
  localparam logic [3:0] OP_INPUT  = 4'd12;
  localparam logic [3:0] OP_OUTPUT = 4'd13;
  localparam logic [3:0] OP_STOP   = 4'd14;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_OP,
    S_DEC_OP,
    S_FETCH_A1,
    S_DEC_A1,
    S_FETCH_A2,
    S_DEC_A2,
    S_READ_M,
    S_EXEC,
    S_DIV,
    S_DIV_END,
    S_WRITE,
    S_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       clr_wr;
    logic       take_req;
    logic       load_wr;
    logic       restart;
    logic [1:0] rd_sel;   // 0 pc, 1 pc+1, 2 pc+2, 3 operand
    logic       rd_en;
    logic       lat_op;
    logic       lat_a1;
    logic       lat_a2;
    logic       lat_m;
    logic       exec;
    logic       div_start;
    logic       div_step;
    logic       div_end;
    logic       mem_wr;
    logic       set_halt;
    status_t    halt_val;
    logic       out_load;
  } ams_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       clr_done;
    action_t    action;
    logic       halted;
    logic       rd_oor;
    logic [3:0] op;
    logic       op_bad;
    logic       a1_oor;
    logic       a2_oor;
    logic       m_zero;
    logic       div_done;
  } ams_sts_t;

endpackage

// ===== rtl/ams_ctrl.sv =====
module ams_ctrl
  import ams_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  ams_sts_t sts,
  output ams_cmd_t cmd,
  output logic     in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  logic uses_a1, is_jump;
  assign is_jump = (sts.op >= OP_JMP) && (sts.op <= OP_JMPZ);
  assign uses_a1 = !is_jump;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (sts.action == ACT_STEP && !sts.halted) state_nxt = S_FETCH_OP;
          else state_nxt = S_RESULT;
        end
      end
      S_FETCH_OP: state_nxt = sts.rd_oor ? S_RESULT : S_DEC_OP;
      S_DEC_OP: begin
        if (sts.op == OP_STOP || sts.op_bad) state_nxt = S_RESULT;
        else state_nxt = S_FETCH_A1;
      end
      S_FETCH_A1: state_nxt = sts.rd_oor ? S_RESULT : S_DEC_A1;
      S_DEC_A1: begin
        if (sts.op == OP_COPY) state_nxt = S_FETCH_A2;
        else if (uses_a1 && sts.a1_oor) state_nxt = S_RESULT;
        else if (is_jump) state_nxt = S_EXEC;
        else state_nxt = S_READ_M;
      end
      S_FETCH_A2: state_nxt = sts.rd_oor ? S_RESULT : S_DEC_A2;
      S_DEC_A2: state_nxt = (sts.a2_oor || sts.a1_oor) ? S_RESULT : S_READ_M;
      S_READ_M:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.op == OP_DIV) state_nxt = sts.m_zero ? S_RESULT : S_DIV;
        else if (sts.op == OP_COPY || sts.op == OP_STORE || sts.op == OP_INPUT)
          state_nxt = S_WRITE;
        else state_nxt = S_RESULT;
      end
      S_DIV:      if (sts.div_done) state_nxt = S_DIV_END;
      S_DIV_END:  state_nxt = S_RESULT;
      S_WRITE:    state_nxt = S_RESULT;
      S_RESULT:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.halt_val = ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take_req = in_fire;
        cmd.load_wr = in_fire && sts.action == ACT_LOAD;
        cmd.restart = in_fire && sts.action == ACT_RESTART;
        cmd.rd_en = in_fire;
        cmd.rd_sel = 2'd0;
      end
      S_FETCH_OP: begin
        cmd.lat_op = 1'b1;
        cmd.set_halt = sts.rd_oor;
        cmd.halt_val = ST_RANGE;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd1;
      end
      S_DEC_OP: begin
        cmd.set_halt = (sts.op == OP_STOP) || sts.op_bad;
        cmd.halt_val = (sts.op == OP_STOP) ? ST_STOP : ST_BADOP;
      end
      S_FETCH_A1: begin
        cmd.lat_a1 = 1'b1;
        cmd.set_halt = sts.rd_oor;
        cmd.halt_val = ST_RANGE;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd2;
      end
      S_DEC_A1: begin
        cmd.set_halt = sts.op != OP_COPY && uses_a1 && sts.a1_oor;
        cmd.halt_val = ST_RANGE;
        // copy keeps the pc+2 word for its second operand
        cmd.rd_en = sts.op != OP_COPY;
        cmd.rd_sel = 2'd3;
      end
      S_FETCH_A2: begin
        cmd.lat_a2 = 1'b1;
        cmd.set_halt = sts.rd_oor;
        cmd.halt_val = ST_RANGE;
      end
      S_DEC_A2: begin
        cmd.set_halt = sts.a2_oor || sts.a1_oor;
        cmd.halt_val = ST_RANGE;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd3;
      end
      S_READ_M: cmd.lat_m = 1'b1;
      S_EXEC: begin
        cmd.exec = !(sts.op == OP_DIV);
        cmd.div_start = (sts.op == OP_DIV) && !sts.m_zero;
        cmd.set_halt = (sts.op == OP_DIV) && sts.m_zero;
        cmd.halt_val = ST_DIVZ;
      end
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_END: cmd.div_end = 1'b1;
      S_WRITE:   cmd.mem_wr = 1'b1;
      S_RESULT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ams_dp.sv =====
module ams_dp
  import ams_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ams_cmd_t    cmd,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_address,
  input  logic [15:0] in_data,
  input  logic [15:0] in_input_value,
  output ams_sts_t    sts,
  output logic [2:0]  r_status,
  output logic [3:0]  r_opcode,
  output logic        r_out_valid,
  output logic [15:0] r_out_value,
  output logic        r_in_used,
  output logic [15:0] r_pc,
  output logic [15:0] r_acc
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [WordW-1:0] mem [MEM_WORDS];
  logic [WordW-1:0] rd_data_r;
  logic             rd_oor_r;
  logic [AW:0]      clr_cnt_r;

  logic [15:0] pc_r, acc_r, a1_r, a2_r, m_r, inval_r;
  logic [3:0]  op_r, opx_r;
  status_t     halt_r;
  action_t     act_r;
  logic        outv_r, inused_r;
  logic [15:0] outval_r;

  // divider
  logic [15:0] dq_r, drem_r, dd_r;
  logic        dneg_r;
  logic [4:0]  dcnt_r;
  logic [16:0] dtrial;

  // read address selection
  logic [16:0] rd_addr17;
  always_comb begin
    unique case (cmd.rd_sel)
      2'd0: rd_addr17 = {1'b0, pc_r};
      2'd1: rd_addr17 = {1'b0, pc_r} + 17'd1;
      2'd2: rd_addr17 = {1'b0, pc_r} + 17'd2;
      default: rd_addr17 = {1'b0, (op_r == OP_COPY) ? a1_r : a1_r};
    endcase
  end
  logic rd_oor;
  assign rd_oor = rd_addr17 >= 17'(MEM_WORDS);

  // write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt_r[AW-1:0];
    end else if (cmd.load_wr) begin
      wr_en = {8'd0, in_address} < 16'(MEM_WORDS);
      wr_addr = AW'({8'd0, in_address});
      wr_data = in_data;
    end else if (cmd.mem_wr) begin
      wr_en = 1'b1;
      priority case (op_r)
        OP_COPY: begin wr_addr = a2_r[AW-1:0]; wr_data = m_r; end
        OP_STORE: begin wr_addr = a1_r[AW-1:0]; wr_data = acc_r; end
        default: begin wr_addr = a1_r[AW-1:0]; wr_data = inval_r; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr17[AW-1:0]];
      rd_oor_r <= rd_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign dtrial = {drem_r, dq_r[15]} - {1'b0, dd_r};

  logic [15:0] acc_abs, m_abs;
  assign acc_abs = acc_r[15] ? 16'(-acc_r) : acc_r;
  assign m_abs   = m_r[15] ? 16'(-m_r) : m_r;

  logic take;
  assign take = (op_r == OP_JMP) || (op_r == OP_JMPN && acc_r[15]) ||
                (op_r == OP_JMPP && !acc_r[15] && acc_r != 16'd0) ||
                (op_r == OP_JMPZ && acc_r == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      acc_r <= '0;
      halt_r <= ST_OK;
    end else begin
      if (cmd.restart) begin
        pc_r <= '0;
        acc_r <= '0;
        halt_r <= ST_OK;
      end
      if (cmd.set_halt) halt_r <= cmd.halt_val;
      if (cmd.exec) begin
        unique case (op_r)
          OP_ADD:  acc_r <= acc_r + m_r;
          OP_SUB:  acc_r <= acc_r - m_r;
          OP_MULT: acc_r <= 16'(acc_r * m_r);
          OP_LOAD: acc_r <= m_r;
          default: ;
        endcase
        if (op_r >= OP_JMP && op_r <= OP_JMPZ) pc_r <= take ? a1_r : pc_r + 16'd2;
        else if (op_r == OP_COPY) pc_r <= pc_r + 16'd3;
        else pc_r <= pc_r + 16'd2;
      end
      if (cmd.div_start) pc_r <= pc_r + 16'd2;
      if (cmd.div_end) acc_r <= dneg_r ? 16'(-dq_r) : dq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      act_r <= action_t'(in_action);
      inval_r <= in_input_value;
      opx_r <= '0;
      outv_r <= 1'b0;
      outval_r <= '0;
      inused_r <= 1'b0;
    end
    if (cmd.lat_op) op_r <= rd_data_r[3:0] | {4{rd_data_r[15:4] != 12'd0}};
    if (cmd.lat_a1) a1_r <= rd_data_r;
    if (cmd.lat_a2) a2_r <= rd_data_r;
    if (cmd.lat_m) m_r <= rd_data_r;
    if (cmd.exec || cmd.div_start) begin
      opx_r <= op_r;
      outv_r <= op_r == OP_OUTPUT;
      outval_r <= (op_r == OP_OUTPUT) ? m_r : 16'd0;
      inused_r <= op_r == OP_INPUT;
    end
    if (cmd.set_halt && cmd.halt_val == ST_STOP) opx_r <= OP_STOP;
    if (cmd.set_halt && cmd.halt_val != ST_STOP) opx_r <= '0;
    if (cmd.div_start) begin
      dq_r <= acc_abs;
      drem_r <= '0;
      dd_r <= m_abs;
      dneg_r <= acc_r[15] ^ m_r[15];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!dtrial[16]) begin
        drem_r <= dtrial[15:0];
        dq_r <= {dq_r[14:0], 1'b1};
      end else begin
        drem_r <= {drem_r[14:0], dq_r[15]};
        dq_r <= {dq_r[14:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  logic op_bad_w;
  assign op_bad_w = (op_r == 4'd0) || (op_r == 4'd15);

  assign sts.clr_done = clr_cnt_r == (AW+1)'(MEM_WORDS - 1);
  assign sts.action   = action_t'(in_action);
  assign sts.halted   = halt_r != ST_OK;
  assign sts.rd_oor   = rd_oor_r;
  assign sts.op       = op_r;
  assign sts.op_bad   = op_bad_w;
  assign sts.a1_oor   = a1_r >= 16'(MEM_WORDS);
  assign sts.a2_oor   = a2_r >= 16'(MEM_WORDS);
  assign sts.m_zero   = m_r == 16'd0;
  assign sts.div_done = dcnt_r == 5'd15;

  logic is_step;
  assign is_step = act_r == ACT_STEP;
  assign r_status    = halt_r;
  assign r_opcode    = is_step ? opx_r : 4'd0;
  assign r_out_valid = is_step & outv_r;
  assign r_out_value = is_step ? outval_r : 16'd0;
  assign r_in_used   = is_step & inused_r;
  assign r_pc        = pc_r;
  assign r_acc       = acc_r;

endmodule

// ===== rtl/accumulator_machine_step.sv =====
// accumulator machine: each request is a load (writes one memory word), a step (runs
// one instruction at pc), a restart (pc and acc to zero, machine running) or none; each
// gives one result. after reset a clearing pass zeroes memory before the first request
// is taken. a load, restart, none or halted step goes straight to the result state;
// a running step goes through fetch and decode states on the single memory port
// (op, operand and operand word reads), and a DIV adds the bit-serial divider.
// the next request is taken once the result has been loaded.
`include "accumulator_machine_step_assert.svh"
module accumulator_machine_step
  import ams_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tuser,   // action[1:0]
  input  logic [39:0] in_tdata,   // address[7:0], data[23:8], input_value[39:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], executed_opcode[6:3], output_valid[7], output_value[23:8],
  // input_used[24], program_counter[40:25], accumulator[56:41]
  output logic [63:0] out_tdata
);

  ams_cmd_t cmd;
  ams_sts_t sts;
  logic in_fire, out_free;
  logic [2:0] r_status;
  logic [3:0] r_opcode;
  logic r_out_valid, r_in_used;
  logic [15:0] r_out_value, r_pc, r_acc;
  logic out_valid_r;
  logic [63:0] out_data_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  ams_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .in_ready(in_tready)
  );

  ams_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_action(in_tuser[1:0]),
    .in_address(in_tdata[7:0]),
    .in_data(in_tdata[23:8]),
    .in_input_value(in_tdata[39:24]),
    .sts,
    .r_status, .r_opcode, .r_out_valid, .r_out_value, .r_in_used, .r_pc, .r_acc
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {7'd0, r_acc, r_pc, r_in_used, r_out_value, r_out_valid,
                     r_opcode, r_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `AMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `AMS_ASSERT_IMPL(a_no_flag_both, clk, rst_n, out_tvalid, !(out_tdata[7] && out_tdata[24]))
  `AMS_ASSERT_IMPL(a_load_not_busy, clk, rst_n, cmd.out_load, !in_tready)

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import ams_pkg::*;

  localparam int MemWords  = 256;
  localparam int StallLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tuser;    // action[1:0]
  logic [39:0] in_tdata;    // address[7:0], data[23:8], input_value[39:24]
  logic        out_tvalid;
  logic        out_tready;
  // status[2:0], executed_opcode[6:3], output_valid[7], output_value[23:8],
  // input_used[24], program_counter[40:25], accumulator[56:41]
  logic [63:0] out_tdata;

  // declared from the top bit down to line up with out_tdata
  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] pc;
    logic        in_used;
    logic [15:0] out_val;
    logic        out_ok;
    logic [3:0]  opcode;
    status_t     status;
  } step_result_t;

  typedef struct {
    action_t     act;
    logic [7:0]  addr;
    logic [15:0] data;
    logic [15:0] in_val;
    logic        has_exp;
    status_t     st;
    logic [15:0] pc;
    logic [15:0] acc;
  } drow_t;

  accumulator_machine_step #(.MEM_WORDS(MemWords)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // machine image kept by the predictor
  logic [15:0]  mem_img [MemWords];
  logic [15:0]  pc_img;
  logic [15:0]  acc_img;
  status_t      halt_img;
  step_result_t pending_results[$];
  int           n_errors;
  int           idle_in_pct;
  int           idle_out_pct;
  int           quiet_cycles;
  bit           timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic bit addr_ok(input logic [16:0] a);
    return a < MemWords;
  endfunction

  function automatic step_result_t run_machine(input action_t act, input logic [7:0] addr,
                                               input logic [15:0] data,
                                               input logic [15:0] in_val);
    step_result_t r;
    logic [15:0]  op, a1, a2, m, q;
    logic [16:0]  pc;
    r = '0;
    case (act)
      ACT_LOAD: begin
        if (addr_ok({9'd0, addr})) mem_img[addr] = data;
      end
      ACT_RESTART: begin
        pc_img = '0;
        acc_img = '0;
        halt_img = ST_OK;
      end
      ACT_STEP: begin
        if (halt_img == ST_OK) begin
          pc = {1'b0, pc_img};
          a2 = '0;
          if (!addr_ok(pc)) halt_img = ST_RANGE;
          else begin
            op = mem_img[pc];
            if (op == 16'(OP_STOP)) begin
              halt_img = ST_STOP;
              r.opcode = OP_STOP;
            end else if (op < 16'(OP_ADD) || op > 16'(OP_STOP)) halt_img = ST_BADOP;
            else if (!addr_ok(pc + 1)) halt_img = ST_RANGE;
            else begin
              a1 = mem_img[pc + 1];
              if (op == 16'(OP_COPY)) begin
                if (!addr_ok(pc + 2)) halt_img = ST_RANGE;
                else begin
                  a2 = mem_img[pc + 2];
                  if (!addr_ok({1'b0, a2})) halt_img = ST_RANGE;
                end
              end
              // jump operands are targets, checked at the next fetch
              if (halt_img == ST_OK && (op < 16'(OP_JMP) || op > 16'(OP_JMPZ))
                  && !addr_ok({1'b0, a1}))
                halt_img = ST_RANGE;
              if (halt_img == ST_OK) begin
                m = (op < 16'(OP_JMP) || op > 16'(OP_JMPZ)) ? mem_img[a1] : 16'd0;
                r.opcode = op[3:0];
                pc_img = 16'(pc + 2);
                case (op[3:0])
                  OP_ADD:  acc_img = acc_img + m;
                  OP_SUB:  acc_img = acc_img - m;
                  OP_MULT: acc_img = acc_img * m;
                  OP_DIV: begin
                    if (m == 0) begin
                      halt_img = ST_DIVZ;
                      r.opcode = '0;
                      pc_img = pc[15:0];
                    end else begin
                      q = 16'($signed(acc_img) / $signed(m));
                      acc_img = q;
                    end
                  end
                  OP_JMP:  pc_img = a1;
                  OP_JMPN: if ($signed(acc_img) < 0) pc_img = a1;
                  OP_JMPP: if ($signed(acc_img) > 0) pc_img = a1;
                  OP_JMPZ: if (acc_img == 0) pc_img = a1;
                  OP_COPY: begin
                    mem_img[a2] = m;
                    pc_img = 16'(pc + 3);
                  end
                  OP_LOAD:  acc_img = m;
                  OP_STORE: mem_img[a1] = acc_img;
                  OP_INPUT: begin
                    mem_img[a1] = in_val;
                    r.in_used = 1'b1;
                  end
                  default: begin
                    r.out_ok = 1'b1;
                    r.out_val = m;
                  end
                endcase
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.status = halt_img;
    r.pc = pc_img;
    r.acc = acc_img;
    return r;
  endfunction

  task automatic send_request(input action_t act, input logic [7:0] addr,
                              input logic [15:0] data, input logic [15:0] in_val);
    while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pending_results.push_back(run_machine(act, addr, data, in_val));
    in_tvalid <= 1'b1;
    in_tuser <= {6'd0, act};
    in_tdata <= {in_val, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
  endtask

  task automatic load_word(input int a, input logic [15:0] w);
    send_request(ACT_LOAD, 8'(a), w, 16'($urandom()));
  endtask

  // receiver side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_out_pct);
  end

  always @(posedge clk) begin
    step_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[56:0];
      if (pending_results.size() == 0) begin
        $display("unexpected result %h at %0t", out_tdata, $time);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", 16'(got.status),
                                                        16'(want.status));
        if (got.opcode !== want.opcode) report_mismatch("opcode", 16'(got.opcode),
                                                        16'(want.opcode));
        if (got.out_ok !== want.out_ok) report_mismatch("output_valid", 16'(got.out_ok),
                                                        16'(want.out_ok));
        if (got.out_val !== want.out_val) report_mismatch("output_value", got.out_val,
                                                          want.out_val);
        if (got.in_used !== want.in_used) report_mismatch("input_used", 16'(got.in_used),
                                                          16'(want.in_used));
        if (got.pc !== want.pc) report_mismatch("pc", got.pc, want.pc);
        if (got.acc !== want.acc) report_mismatch("acc", got.acc, want.acc);
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random program: mostly valid instructions with in-range operands
  task automatic random_program(input int len);
    int k, op, opnd;
    for (k = 0; k < len; k++) begin
      op = $urandom_range(99) < 4 ? $urandom_range(15) : $urandom_range(13, 1);
      if ($urandom_range(99) < 2) op = $urandom_range(65535);
      opnd = $urandom_range(99) < 3 ? $urandom_range(65535) : $urandom_range(MemWords - 1);
      if (op >= OP_JMP && op <= OP_JMPZ && $urandom_range(99) < 80)
        opnd = $urandom_range(40);
      load_word(2 * k, 16'(op));
      load_word(2 * k + 1, 16'(opnd));
    end
  endtask

  task automatic random_phase(input int items);
    int n, t, a, len;
    n = 0;
    while (n < items) begin
      if ($urandom_range(99) < 25) begin
        send_request(ACT_RESTART, 8'($urandom()), 16'($urandom()), 16'($urandom()));
        len = $urandom_range(1, 8);
        random_program(len);
        n += 1 + 2 * len;
      end
      t = $urandom_range(99);
      if (t < 70) send_request(ACT_STEP, 8'($urandom()), 16'($urandom()), 16'($urandom()));
      else if (t < 85) begin
        a = $urandom_range(99) < 50 ? $urandom_range(MemWords - 1) : $urandom_range(255);
        if ($urandom_range(3) == 0) a = 200 + $urandom_range(55);
        send_request(ACT_LOAD, 8'(a), 16'($urandom()), 16'($urandom()));
      end else if (t < 95)
        send_request(ACT_RESTART, 8'($urandom()), 16'($urandom()), 16'($urandom()));
      else send_request(ACT_NONE, 8'($urandom()), 16'($urandom()), 16'($urandom()));
      n++;
    end
  endtask

  drow_t directed[$];
  int    i;

  function automatic drow_t mk(input action_t a, input logic [7:0] ad, input logic [15:0] d,
                               input logic [15:0] iv, input logic e, input status_t s,
                               input logic [15:0] p, input logic [15:0] c);
    drow_t r;
    r.act = a; r.addr = ad; r.data = d; r.in_val = iv;
    r.has_exp = e; r.st = s; r.pc = p; r.acc = c;
    return r;
  endfunction

  initial begin
    step_result_t w;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    n_errors = 0;
    idle_in_pct = 26;
    idle_out_pct = 74;
    foreach (mem_img[k]) mem_img[k] = '0;
    pc_img = '0;
    acc_img = '0;
    halt_img = ST_OK;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero memory: opcode 0 is invalid
    directed.push_back(mk(ACT_STEP, 8'h00, 16'h0000, 16'hffff, 1, ST_BADOP, 16'd0, 16'd0));
    directed.push_back(mk(ACT_STEP, 8'h00, 16'h0000, 16'h0000, 1, ST_BADOP, 16'd0, 16'd0));
    directed.push_back(mk(ACT_LOAD, 8'hff, 16'h8000, 16'hffff, 1, ST_BADOP, 16'd0, 16'd0));
    directed.push_back(mk(ACT_NONE, 8'hff, 16'hffff, 16'hffff, 1, ST_BADOP, 16'd0, 16'd0));
    directed.push_back(mk(ACT_RESTART, 8'hff, 16'hffff, 16'hffff, 1, ST_OK, 16'd0, 16'd0));
    // small program: LOAD 255; DIV 200; INPUT 201; OUTPUT 201; DIV 202
    directed.push_back(mk(ACT_LOAD, 8'd0, 16'(OP_LOAD), 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd1, 16'd255, 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd200, 16'hffff, 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd2, 16'(OP_DIV), 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd3, 16'd200, 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd4, 16'(OP_INPUT), 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd5, 16'd201, 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd6, 16'(OP_OUTPUT), 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd7, 16'd201, 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd8, 16'(OP_DIV), 0, 0, ST_OK, 0, 0));
    directed.push_back(mk(ACT_LOAD, 8'd9, 16'd202, 0, 0, ST_OK, 0, 0));
    for (i = 0; i < 5; i++)
      directed.push_back(mk(ACT_STEP, 8'd0, 16'd0, 16'h7fff, 0, ST_OK, 0, 0));
    // divide by zero halts, then stepping stays halted
    directed.push_back(mk(ACT_STEP, 8'd0, 16'd0, 16'd0, 1, ST_DIVZ, 16'd8, 16'h8000));
    directed.push_back(mk(ACT_STEP, 8'd0, 16'd0, 16'd0, 1, ST_DIVZ, 16'd8, 16'h8000));

    idle_in_pct = 26;
    idle_out_pct = 74;
    pending_results.delete();
    foreach (directed[k]) begin
      send_request(directed[k].act, directed[k].addr, directed[k].data, directed[k].in_val);
      if (directed[k].has_exp) begin
        w = pending_results[pending_results.size() - 1];
        if (w.status !== directed[k].st || w.pc !== directed[k].pc ||
            w.acc !== directed[k].acc) begin
          $display("directed row %0d disagrees with predictor", k);
          n_errors++;
        end
      end
    end
    // acc was 0x8000 before the first DIV by -1: row above expects the wrap
    drain();

    // other opcodes, stop and range cases through a fixed program
    send_request(ACT_RESTART, 0, 0, 0);
    load_word(0, 16'(OP_STORE)); load_word(1, 16'd203);
    load_word(2, 16'(OP_JMPZ)); load_word(3, 16'd6);
    load_word(6, 16'(OP_JMPP)); load_word(7, 16'd0);
    load_word(8, 16'(OP_JMP)); load_word(9, 16'd254);
    load_word(254, 16'(OP_ADD)); load_word(255, 16'd0);
    repeat (6) send_request(ACT_STEP, 0, 0, 0);
    send_request(ACT_RESTART, 0, 0, 0);
    load_word(0, 16'(OP_ADD)); load_word(1, 16'hffff);
    send_request(ACT_STEP, 0, 0, 0);
    send_request(ACT_RESTART, 0, 0, 0);
    load_word(0, 16'(OP_JMP)); load_word(1, 16'h1234);
    repeat (2) send_request(ACT_STEP, 0, 0, 0);
    send_request(ACT_RESTART, 0, 0, 0);
    load_word(0, 16'(OP_STOP));
    repeat (2) send_request(ACT_STEP, 0, 0, 0);
    drain();

    random_phase(650);
    drain();
    idle_in_pct = 74;
    idle_out_pct = 26;
    random_phase(650);
    drain();
    idle_in_pct = 0;
    idle_out_pct = 0;
    random_phase(650);
    drain();
    repeat (40) @(posedge clk);

    if (n_errors == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== accumulator_machine_step.f =====
+incdir+rtl
rtl/ams_pkg.sv
rtl/ams_ctrl.sv
rtl/ams_dp.sv
rtl/accumulator_machine_step.sv
tb/sv/tb_top.sv
